// ===== rtl/dpuf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpuf_pkg
// Shared types and constants of the deadband position update filter.
// ----------------------------------------------------------------------------
package dpuf_pkg;

	localparam int NUM_TRACKS = 1024;
	localparam int TRK_W      = $clog2(NUM_TRACKS);
	localparam int POS_W      = 24;
	localparam int TIME_W     = 32;
	localparam int CNT_W      = 11;
	localparam int TH_W       = 50;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 96;

	localparam logic [TRK_W-1:0] TRK_LAST  = TRK_W'(NUM_TRACKS - 1);
	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	localparam logic [TH_W-1:0]   DIST_TH_SQ_RST = TH_W'(1000000);
	localparam logic [TIME_W-1:0] AGE_LIMIT_RST  = TIME_W'(1000);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_TH_SQ = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INCR_MODE  = 2'd2;

	// operation codes
	localparam logic OP_CHECK  = 1'b0;
	localparam logic OP_FORCED = 1'b1;

	typedef struct packed {
		logic                    seen;
		logic [TIME_W-1:0]       last_time;
		logic signed [POS_W-1:0] last_z;
		logic signed [POS_W-1:0] last_y;
		logic signed [POS_W-1:0] last_x;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic                    operation;
		logic                    scan_start;
		logic [TRK_W-1:0]        track;
		logic signed [POS_W-1:0] pos_x;
		logic signed [POS_W-1:0] pos_y;
		logic signed [POS_W-1:0] pos_z;
		logic [TIME_W-1:0]       now;
	} item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_DECIDE
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/dpuf_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dpuf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dpuf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire [$clog2(DEPTH)-1:0]  waddr,
	input  wire [WIDTH-1:0]          wdata,
	input  wire [$clog2(DEPTH)-1:0]  raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/deadband_position_update_filter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadband_position_update_filter_top
// Per-track send-on-delta filter with heartbeat timeout.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel (track, position, time; tuser carries
// operation and scan_start) and leave one-for-one on the m_axis channel.
// m_axis_tuser is the update flag; tdata echoes track and position with the
// per-scan update count. Configuration is written through cfg_we/cfg_addr/
// cfg_wdata while no item is in flight.
// Per-track state lives in one RAM word (position, time, seen bit). An item
// passes through the RAM read, abs differences and age check, squares, then
// sum/compare with write-back. A new item is accepted only after the last
// one has left the decide step. Only one item is in flight, so no
// forwarding is needed.
// After reset the block sweeps the RAM clearing every entry, one per cycle:
// s_axis_tready stays low until the sweep has cleared the last entry.
// The output register holds a result while m_axis_tready is low; the next
// item is still accepted and waits in the decide step until the result
// has been taken.
// ----------------------------------------------------------------------------
module deadband_position_update_filter_top
	import dpuf_pkg::*;
(
	input  wire                    clk,
	input  wire                    arst_n,
	// configuration
	input  wire                    cfg_we,
	input  wire [CFG_IDX_W-1:0]    cfg_addr,
	input  wire [TH_W-1:0]         cfg_wdata,
	// input items
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_DATA_W-1:0]    s_axis_tdata,  // track, pos_x, pos_y, pos_z, now, pad
	input  wire [1:0]              s_axis_tuser,  // operation, scan_start
	// result items
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,  // track_out, x_out, y_out, z_out,
	                                              // updates_in_scan, pad
	output logic                   m_axis_tuser   // update_point
);

	state_t state_q, state_d;

	logic [TH_W-1:0]   dist_th_sq_q;
	logic [TIME_W-1:0] age_limit_q;
	logic              incr_mode_q;

	logic [TRK_W-1:0]  clr_q;
	item_t             item_q;
	logic [CNT_W-1:0]  count_q;

	entry_t            rd_entry;
	logic              mem_we;
	logic [TRK_W-1:0]  mem_waddr;
	entry_t            mem_wdata;

	logic [POS_W:0]    absd_s2 [3];
	logic              seen_s2;
	logic              age_hit_s2;
	logic [2*POS_W+1:0] sq_s3 [3];
	logic              seen_s3;
	logic              age_hit_s3;

	logic [TH_W+1:0]   d2;
	logic              upd;
	logic              out_load;
	logic              in_accept;
	logic [CNT_W-1:0]  count_base;
	logic [CNT_W-1:0]  count_next;

	logic                    out_valid_q;
	logic                    out_upd_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_th_sq_q <= DIST_TH_SQ_RST;
			age_limit_q  <= AGE_LIMIT_RST;
			incr_mode_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_DIST_TH_SQ: dist_th_sq_q <= cfg_wdata;
				CFG_AGE_LIMIT:  age_limit_q  <= cfg_wdata[TIME_W-1:0];
				CFG_INCR_MODE:  incr_mode_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	dpuf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_TRACKS)
	) u_track_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (s_axis_tdata[TRK_W-1:0]),
		.rdata (rd_entry)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + TRK_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (clr_q == TRK_LAST) state_d = ST_IDLE;
			ST_IDLE:   if (in_accept) state_d = ST_READ;
			ST_READ:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_DECIDE;
			ST_DECIDE: if (out_load) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = item_q.track;
		mem_wdata     = '{seen: 1'b1, last_time: item_q.now, last_z: item_q.pos_z,
		                  last_y: item_q.pos_y, last_x: item_q.pos_x};
		out_load      = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_READ:   ;
			ST_SQUARE: ;
			ST_DECIDE: begin
				out_load = !out_valid_q || m_axis_tready;
				mem_we   = out_load && upd;
			end
			default: ;
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= '{operation: s_axis_tuser[0], scan_start: s_axis_tuser[1],
			            track: s_axis_tdata[9:0], pos_x: s_axis_tdata[33:10],
			            pos_y: s_axis_tdata[57:34], pos_z: s_axis_tdata[81:58],
			            now: s_axis_tdata[113:82]};
		end
	end

	// read step: absolute differences and age check
	always_ff @(posedge clk) begin
		logic signed [POS_W:0] dx, dy, dz;
		logic [TIME_W-1:0]     age;
		dx = {item_q.pos_x[POS_W-1], item_q.pos_x} - {rd_entry.last_x[POS_W-1], rd_entry.last_x};
		dy = {item_q.pos_y[POS_W-1], item_q.pos_y} - {rd_entry.last_y[POS_W-1], rd_entry.last_y};
		dz = {item_q.pos_z[POS_W-1], item_q.pos_z} - {rd_entry.last_z[POS_W-1], rd_entry.last_z};
		age = item_q.now - rd_entry.last_time;
		if (state_q == ST_READ) begin
			absd_s2[0] <= dx[POS_W] ? -dx : dx;
			absd_s2[1] <= dy[POS_W] ? -dy : dy;
			absd_s2[2] <= dz[POS_W] ? -dz : dz;
			seen_s2    <= rd_entry.seen;
			age_hit_s2 <= age >= age_limit_q;
		end
	end

	// square step
	always_ff @(posedge clk) begin
		if (state_q == ST_SQUARE) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= (2*POS_W+2)'(absd_s2[i]) * (2*POS_W+2)'(absd_s2[i]);
			end
			seen_s3    <= seen_s2;
			age_hit_s3 <= age_hit_s2;
		end
	end

	// decide step
	always_comb begin
		d2  = (TH_W+2)'(sq_s3[0]) + (TH_W+2)'(sq_s3[1]) + (TH_W+2)'(sq_s3[2]);
		upd = (item_q.operation == OP_FORCED) || !incr_mode_q || !seen_s3
		      || (d2 > {2'b00, dist_th_sq_q}) || age_hit_s3;
		count_base = item_q.scan_start ? '0 : count_q;
		count_next = (upd && count_base != COUNT_MAX) ? count_base + CNT_W'(1) : count_base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_upd_q  <= upd;
			out_data_q <= {3'b000, count_next, item_q.pos_z, item_q.pos_y,
			               item_q.pos_x, item_q.track};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_upd_q;
	assign m_axis_tdata  = out_data_q;

	// a finished item shows up in the next cycle with the sequencer free again
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (m_axis_tvalid && state_q == ST_IDLE))
		else $error("result not presented after decide step");

	// an update always leaves a nonzero count behind
	a_update_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[92:82] != '0))
		else $error("update reported with zero count");

	// count moves only when an item completes
	a_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> $stable(count_q))
		else $error("update count changed without a finished item");

	// clearing sweep ends only after the last entry
	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (state_q == ST_CLEAR
		|| (state_q == ST_IDLE && $past(clr_q) == TRK_LAST)))
		else $error("clearing sweep left early");

	// write-back only for an update or during the sweep
	a_write_cause: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ST_CLEAR || (state_q == ST_DECIDE && upd && out_load)))
		else $error("unexpected track RAM write");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadband position update filter testbench
// Drives track items through the stream input while both sides idle at random.
// A predictor keeps its own per-track copy of position, time and seen state,
// plus the filter registers. It queues the expected result for each accepted
// item. Every result is checked field by field against the oldest expected
// one. The register settings include the corner values.
// ----------------------------------------------------------------------------
module testbench;
	import dpuf_pkg::*;

	localparam int RUN_LIMIT = 1000000;

	typedef struct {
		logic                    upd;
		logic [TRK_W-1:0]        trk;
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [CNT_W-1:0]        cnt;
	} point_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_addr = '0;
	logic [TH_W-1:0]        cfg_wdata = '0;
	logic                   s_tvalid = 1'b0;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [1:0]             s_tuser = '0;
	logic                   s_axis_tready;
	logic                   m_axis_tvalid;
	logic                   m_ready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tuser;

	// predictor state
	logic signed [POS_W-1:0] track_x [NUM_TRACKS];
	logic signed [POS_W-1:0] track_y [NUM_TRACKS];
	logic signed [POS_W-1:0] track_z [NUM_TRACKS];
	logic [TIME_W-1:0]       track_time [NUM_TRACKS];
	bit                      track_seen [NUM_TRACKS];
	logic [CNT_W-1:0]        scan_updates = '0;
	logic [TH_W-1:0]         th_sq = DIST_TH_SQ_RST;
	logic [TIME_W-1:0]       age_lim = AGE_LIMIT_RST;
	logic                    incr_mode = 1'b1;

	point_result_t    expected_points [$];
	logic [TRK_W-1:0] track_pool [16];
	int               errors = 0;
	int               cycles = 0;
	int               burst_left = 0;

	deadband_position_update_filter_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int i = 0; i < NUM_TRACKS; i++) begin
			track_x[i] = '0;
			track_y[i] = '0;
			track_z[i] = '0;
			track_time[i] = '0;
			track_seen[i] = 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("MISMATCH @%0t: %s", $realtime, what);
		errors++;
	endtask

	// Track numbers are 10 bits wide and NUM_TRACKS is 1024, so every track is in range.
	task automatic filter_track_item(input item_t it);
		point_result_t r;
		longint dx, dy, dz;
		longint unsigned d2;
		logic [TIME_W-1:0] age;
		logic upd;
		if (it.scan_start)
			scan_updates = '0;
		upd = (it.operation == OP_FORCED) || !incr_mode || !track_seen[it.track];
		if (!upd) begin
			dx = longint'(it.pos_x) - longint'(track_x[it.track]);
			dy = longint'(it.pos_y) - longint'(track_y[it.track]);
			dz = longint'(it.pos_z) - longint'(track_z[it.track]);
			d2 = longint'(dx * dx + dy * dy + dz * dz);
			age = it.now - track_time[it.track];
			upd = (d2 > 64'(th_sq)) || (age >= age_lim);
		end
		if (upd) begin
			track_x[it.track] = it.pos_x;
			track_y[it.track] = it.pos_y;
			track_z[it.track] = it.pos_z;
			track_time[it.track] = it.now;
			track_seen[it.track] = 1'b1;
			if (scan_updates != COUNT_MAX)
				scan_updates = scan_updates + 1'b1;
		end
		r.upd = upd;
		r.trk = it.track;
		r.x = it.pos_x;
		r.y = it.pos_y;
		r.z = it.pos_z;
		r.cnt = scan_updates;
		expected_points.push_back(r);
	endtask

	always @(posedge clk) begin : check_points
		point_result_t want;
		logic signed [POS_W-1:0] gx, gy, gz;
		if (m_axis_tvalid && m_ready) begin
			gx = m_axis_tdata[33:10];
			gy = m_axis_tdata[57:34];
			gz = m_axis_tdata[81:58];
			if (expected_points.size() == 0) begin
				flag_mismatch($sformatf("result for track %0d with no item pending",
					m_axis_tdata[9:0]));
			end else begin
				want = expected_points.pop_front();
				if (m_axis_tuser !== want.upd)
					flag_mismatch($sformatf("track %0d update_point %b, want %b",
						want.trk, m_axis_tuser, want.upd));
				if (m_axis_tdata[9:0] !== want.trk)
					flag_mismatch($sformatf("track_out %0d, want %0d",
						m_axis_tdata[9:0], want.trk));
				if (gx !== want.x)
					flag_mismatch($sformatf("track %0d x_out %0d, want %0d", want.trk, gx, want.x));
				if (gy !== want.y)
					flag_mismatch($sformatf("track %0d y_out %0d, want %0d", want.trk, gy, want.y));
				if (gz !== want.z)
					flag_mismatch($sformatf("track %0d z_out %0d, want %0d", want.trk, gz, want.z));
				if (m_axis_tdata[92:82] !== want.cnt)
					flag_mismatch($sformatf("track %0d updates_in_scan %0d, want %0d",
						want.trk, m_axis_tdata[92:82], want.cnt));
			end
		end
	end

	// result side: ready runs, short and long stalls, now and then a long stretch without one
	initial begin : sink_stalls
		int sel, hi, lo;
		forever begin
			sel = $urandom_range(0, 99);
			if (sel < 10) begin
				hi = $urandom_range(50, 200);
				lo = 0;
			end else begin
				hi = $urandom_range(1, 6);
				lo = (sel < 88) ? $urandom_range(1, 3) : $urandom_range(10, 40);
			end
			@(negedge clk);
			m_ready <= 1'b1;
			repeat (hi - 1) @(negedge clk);
			if (lo > 0) begin
				@(negedge clk);
				m_ready <= 1'b0;
				repeat (lo - 1) @(negedge clk);
			end
		end
	end

	task automatic send_item(input item_t it);
		int gap, sel;
		if (burst_left > 0) begin
			burst_left--;
			gap = 0;
		end else begin
			sel = $urandom_range(0, 99);
			if (sel < 4)
				burst_left = $urandom_range(20, 60);
			if (sel < 60)
				gap = 0;
			else if (sel < 90)
				gap = $urandom_range(1, 3);
			else
				gap = $urandom_range(8, 30);
		end
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, it.now, it.pos_z, it.pos_y, it.pos_x, it.track};
		s_tuser <= {it.scan_start, it.operation};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		filter_track_item(it);
	endtask

	// stop sending and let every pending result come out
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_points.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TH_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_DIST_TH_SQ: th_sq = value;
			CFG_AGE_LIMIT:  age_lim = value[TIME_W-1:0];
			CFG_INCR_MODE:  incr_mode = value[0];
			default: ;
		endcase
	endtask

	task automatic set_filter(input logic [TH_W-1:0] th, input logic [TIME_W-1:0] age,
			input logic incr);
		drain_results();
		write_reg(CFG_DIST_TH_SQ, th);
		write_reg(CFG_AGE_LIMIT, TH_W'(age));
		write_reg(CFG_INCR_MODE, TH_W'(incr));
	endtask

	function automatic item_t mk_item(input logic op, input logic start, input int trk,
			input int x, input int y, input int z, input logic [TIME_W-1:0] now);
		item_t it;
		it.operation = op;
		it.scan_start = start;
		it.track = trk[TRK_W-1:0];
		it.pos_x = x[POS_W-1:0];
		it.pos_y = y[POS_W-1:0];
		it.pos_z = z[POS_W-1:0];
		it.now = now;
		return it;
	endfunction

	// Mostly moves of tracks from a small pool close to the distance and age
	// thresholds; the rest is fully random.
	function automatic item_t stream_item();
		item_t it;
		int rad;
		logic [TRK_W-1:0] trk;
		logic [TIME_W-1:0] age;
		if ($urandom_range(0, 99) < 12) begin
			it.operation = 1'($urandom_range(0, 1));
			it.scan_start = 1'($urandom_range(0, 1));
			it.track = TRK_W'($urandom);
			it.pos_x = POS_W'($urandom);
			it.pos_y = POS_W'($urandom);
			it.pos_z = POS_W'($urandom);
			it.now = $urandom;
			return it;
		end
		if (th_sq > TH_W'(64'd70368744177664))
			rad = 8388607;
		else
			rad = int'($sqrt(real'(th_sq)) * 0.7) + 1;
		trk = track_pool[$urandom_range(0, 15)];
		if ($urandom_range(0, 1))
			age = age_lim + TIME_W'($urandom_range(0, 4)) - 32'd2;
		else
			age = $urandom_range(0, 2000);
		it.operation = ($urandom_range(0, 99) < 8) ? OP_FORCED : OP_CHECK;
		it.scan_start = ($urandom_range(0, 99) < 3);
		it.track = trk;
		it.pos_x = track_x[trk] + POS_W'($urandom_range(0, 2 * rad) - rad);
		it.pos_y = track_y[trk] + POS_W'($urandom_range(0, 2 * rad) - rad);
		it.pos_z = track_z[trk] + POS_W'($urandom_range(0, 2 * rad) - rad);
		it.now = track_time[trk] + age;
		return it;
	endfunction

	task automatic test_directed();
		// new track, then moves right at the reset threshold of 1000000
		send_item(mk_item(OP_CHECK, 1'b1, 5, 0, 0, 0, 100));
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1000, 0, 0, 200));
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1001, 0, 0, 300));
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1001, 0, 0, 1299));
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1001, 0, 0, 1300));
		send_item(mk_item(OP_FORCED, 1'b0, 5, 1001, 0, 0, 1300));
		// two axes adding up to exactly the threshold
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1601, 800, 0, 1301));
		send_item(mk_item(OP_CHECK, 1'b0, 5, 1001, 0, -1001, 1302));
		// age across the time wrap
		send_item(mk_item(OP_FORCED, 1'b0, 7, 0, 0, 0, 32'hFFFF_FF00));
		send_item(mk_item(OP_CHECK, 1'b0, 7, 0, 0, 0, 32'h0000_00E7));
		send_item(mk_item(OP_CHECK, 1'b0, 7, 0, 0, 0, 32'h0000_02E8));
		// position and track extremes
		send_item(mk_item(OP_CHECK, 1'b0, 1023, -8388608, -8388608, -8388608, 0));
		send_item(mk_item(OP_CHECK, 1'b0, 1023, 8388607, 8388607, 8388607, 1));
		send_item(mk_item(OP_CHECK, 1'b0, 1023, 8388606, 8388607, 8388607, 2));
		send_item(mk_item(OP_CHECK, 1'b0, 0, 8388607, -8388608, 8388607, 32'hFFFF_FFFF));
		send_item(mk_item(OP_CHECK, 1'b0, 0, 8388600, -8388600, 8388600, 32'hFFFF_FFFF));
		send_item(mk_item(OP_CHECK, 1'b0, 0, 8388607, -8388608, 8388607, 32'h0000_03E6));
		send_item(mk_item(OP_CHECK, 1'b0, 0, 8388607, -8388608, 8388607, 32'h0000_03E7));
		// scan restart on a forced item, and on one that does not update
		send_item(mk_item(OP_FORCED, 1'b1, 1023, 5, -5, 5, 32'h8000_0000));
		send_item(mk_item(OP_CHECK, 1'b1, 1023, 5, -5, 5, 32'h8000_0001));
		send_item(mk_item(OP_CHECK, 1'b0, 512, -1, -1, -1, 32'h5555_5555));
	endtask

	task automatic run_stream(input int n);
		for (int i = 0; i < n; i++)
			send_item(stream_item());
	endtask

	task automatic test_config_corners();
		for (int i = 0; i < 16; i++)
			track_pool[i] = TRK_W'($urandom);
		// zero threshold: any movement at all updates
		set_filter('0, 32'hFFFF_FFFF, 1'b1);
		run_stream(60);
		// zero age limit: every item updates
		set_filter({TH_W{1'b1}}, '0, 1'b1);
		run_stream(40);
		// largest threshold, smallest nonzero age limit
		set_filter({TH_W{1'b1}}, 32'd1, 1'b1);
		run_stream(60);
		// both at their largest: only forced items, new tracks and an age of exactly the limit update
		set_filter({TH_W{1'b1}}, 32'hFFFF_FFFF, 1'b1);
		run_stream(60);
		// rebuild mode
		set_filter(TH_W'(1), 32'd1, 1'b0);
		run_stream(60);
		set_filter(DIST_TH_SQ_RST, AGE_LIMIT_RST, 1'b1);
		run_stream(60);
	endtask

	task automatic test_random_tracks();
		logic [TH_W-1:0] th [4];
		logic [TIME_W-1:0] age [4];
		th[0] = DIST_TH_SQ_RST;       age[0] = AGE_LIMIT_RST;
		th[1] = TH_W'(1) << 20;        age[1] = 32'd5000;
		th[2] = TH_W'(64'd1) << 44;    age[2] = 32'd37;
		th[3] = TH_W'($urandom);       age[3] = $urandom_range(1, 100000);
		for (int p = 0; p < 4; p++) begin
			for (int i = 0; i < 16; i++)
				track_pool[i] = TRK_W'($urandom);
			set_filter(th[p], age[p], 1'b1);
			for (int i = 0; i < 220; i++) begin
				if (i == 110)
					drain_results();
				send_item(stream_item());
			end
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_config_corners();
		test_random_tracks();
		drain_results();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== deadband_position_update_filter_top.f =====
rtl/dpuf_pkg.sv
rtl/dpuf_ram.sv
rtl/deadband_position_update_filter_top.sv
verif/testbench.sv
